@@ src/utf8d_pkg.sv @@
`timescale 1ns / 1ps
// Package for the UTF-8 byte stream decoder: field types and lead byte constants.
// No dependencies; used by the channel interfaces and the decoder unit.
package utf8d_pkg;

  localparam int unsigned ByteWidth      = 8;
  localparam int unsigned CodePointWidth = 21;
  localparam int unsigned SeqLenWidth    = 3;
  localparam int unsigned RemainWidth    = 2;
  localparam int unsigned ContBits       = 6;

  typedef logic [ByteWidth-1:0]      byte_t;
  typedef logic [CodePointWidth-1:0] code_point_t;
  typedef logic [SeqLenWidth-1:0]    seq_len_t;
  typedef logic [RemainWidth-1:0]    remain_t;

  // Lead byte class boundaries
  localparam byte_t LeadTwoMin   = 8'h80;
  localparam byte_t LeadThreeMin = 8'hE0;
  localparam byte_t LeadFourMin  = 8'hF0;
  localparam byte_t LeadRawMin   = 8'hF8;

  // Payload masks
  localparam byte_t MaskTwo   = 8'h1F;
  localparam byte_t MaskThree = 8'h0F;
  localparam byte_t MaskFour  = 8'h07;
  localparam byte_t MaskCont  = 8'h3F;

  // Sequence lengths
  localparam seq_len_t LenOne   = 3'd1;
  localparam seq_len_t LenTwo   = 3'd2;
  localparam seq_len_t LenThree = 3'd3;
  localparam seq_len_t LenFour  = 3'd4;

  // Continuation bytes still expected
  localparam remain_t RemNone  = 2'd0;
  localparam remain_t RemOne   = 2'd1;
  localparam remain_t RemTwo   = 2'd2;
  localparam remain_t RemThree = 2'd3;

endpackage

@@ src/utf8d_byte_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel carrying one raw byte of the text stream per item.
// Depends on utf8d_pkg for the byte type.
interface utf8d_byte_if
  import utf8d_pkg::*;
();
  logic  valid;
  logic  ready;
  byte_t in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

@@ src/utf8d_cp_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel carrying one decoded code point and its length per item.
// Depends on utf8d_pkg for the field types.
interface utf8d_cp_if
  import utf8d_pkg::*;
();
  logic        valid;
  logic        ready;
  code_point_t code_point;
  seq_len_t    sequence_length;

  modport source (output valid, output code_point, output sequence_length, input ready);
  modport sink   (input valid, input code_point, input sequence_length, output ready);
endinterface

@@ src/utf8_byte_stream_decoder_unit.sv @@
`timescale 1ns / 1ps
// UTF-8 byte stream decoder: bytes in, code points out.
// Depends on utf8d_pkg, utf8d_byte_if and utf8d_cp_if.
//
//   channel | direction | payload                          | items
//   --------+-----------+----------------------------------+---------------------------
//   in_i    | sink      | in_byte[7:0]                     | one per raw byte
//   out_o   | source    | code_point[20:0], sequence_length | one per completed sequence
//
// One byte per cycle is taken and decoded while out_o does not stall; the byte that
// completes a result passes the input register, then the result register.
// The decode step between the two registers is combinational.
// Reset (rst_ni low, asynchronous) empties both registers and returns the decoder
// to expecting a lead byte. When out_o stalls, hold the result and the staged
// byte; in_i keeps accepting while the input register is free or will drain.
module utf8_byte_stream_decoder_unit
  import utf8d_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  utf8d_byte_if.sink in_i,
  utf8d_cp_if.source out_o
);

  // Input register stage
  logic  in_vld_q;
  byte_t in_byte_q;

  // Decoder state
  remain_t     rem_q, rem_d;
  code_point_t partial_q, partial_d;
  seq_len_t    len_q, len_d;

  // Result register stage
  logic        out_vld_q, out_vld_d;
  code_point_t out_cp_q, out_cp_d;
  seq_len_t    out_len_q, out_len_d;

  logic        advance;   // result slot free or draining this cycle
  logic        emit;
  code_point_t merged;
  code_point_t lead_payload;

  assign advance  = !out_vld_q || out_o.ready;
  assign in_i.ready = !in_vld_q || advance;

  assign out_o.valid           = out_vld_q;
  assign out_o.code_point      = out_cp_q;
  assign out_o.sequence_length = out_len_q;

  // Shift in the low six bits of a continuation byte; keep 21 bits.
  assign merged = {partial_q[CodePointWidth-ContBits-1:0], in_byte_q[ContBits-1:0]};

  always_comb begin
    rem_d        = rem_q;
    partial_d    = partial_q;
    len_d        = len_q;
    emit         = 1'b0;
    out_cp_d     = out_cp_q;
    out_len_d    = out_len_q;
    lead_payload = code_point_t'(in_byte_q);

    if (in_vld_q && advance) begin
      if (rem_q == RemNone) begin
        // Lead byte: classify by range.
        priority if (in_byte_q < LeadTwoMin || in_byte_q >= LeadRawMin) begin
          // ASCII or an invalid lead: pass through as its own code point.
          emit      = 1'b1;
          out_cp_d  = code_point_t'(in_byte_q);
          out_len_d = LenOne;
        end else if (in_byte_q < LeadThreeMin) begin
          lead_payload = code_point_t'(in_byte_q & MaskTwo);
          partial_d    = lead_payload;
          len_d        = LenTwo;
          rem_d        = RemOne;
        end else if (in_byte_q < LeadFourMin) begin
          lead_payload = code_point_t'(in_byte_q & MaskThree);
          partial_d    = lead_payload;
          len_d        = LenThree;
          rem_d        = RemTwo;
        end else begin
          lead_payload = code_point_t'(in_byte_q & MaskFour);
          partial_d    = lead_payload;
          len_d        = LenFour;
          rem_d        = RemThree;
        end
      end else begin
        // Continuation byte, taken unchecked.
        rem_d = rem_q - RemOne;
        if (rem_q == RemOne) begin
          emit      = 1'b1;
          out_cp_d  = merged;
          out_len_d = len_q;
          partial_d = '0;
          len_d     = LenOne;
        end else begin
          partial_d = merged;
        end
      end
    end

    out_vld_d = advance ? emit : out_vld_q;
  end

  // Control and decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      rem_q     <= RemNone;
      partial_q <= '0;
      len_q     <= LenOne;
    end else begin
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      out_vld_q <= out_vld_d;
      rem_q     <= rem_d;
      partial_q <= partial_d;
      len_q     <= len_d;
    end
  end

  // Payload registers: load on handshake or on a new result.
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q <= in_i.in_byte;
    end
    if (advance && emit) begin
      out_cp_q  <= out_cp_d;
      out_len_q <= out_len_d;
    end
  end

endmodule

@@ bench/tb_utf8_byte_stream_decoder_unit.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the UTF-8 byte stream decoder: drives bytes, predicts code points.
// Depends on utf8d_pkg, utf8d_byte_if, utf8d_cp_if and utf8_byte_stream_decoder_unit.
module tb_utf8_byte_stream_decoder_unit;
  import utf8d_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int unsigned DRAIN_LIMIT = 2_000;
  localparam int unsigned DRAIN_TAIL  = 16;

  // One decoded code point together with the number of bytes it took
  typedef struct packed {
    code_point_t cp;
    seq_len_t    len;
  } cp_result_t;

  logic clk_i;
  logic rst_ni;

  utf8d_byte_if byte_ch ();
  utf8d_cp_if   cp_ch ();

  utf8_byte_stream_decoder_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_ch),
    .out_o  (cp_ch)
  );

  // Code points still owed by the decoder, oldest first
  cp_result_t  pending_cps[$];
  cp_result_t  oldest_cp;
  int unsigned mismatch_count;
  int unsigned cycle_count;

  // Decoder state as the bench tracks it
  remain_t     cont_left;
  code_point_t partial_cp;
  seq_len_t    seq_len;

  // Idling switches for the sender and the receiver
  bit src_idle_on;
  bit sink_stall_on;
  int unsigned stall_left;

  // Clock: 10 ns period
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: end the run as failed once the cycle limit is reached
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  // Print one line per mismatch and count it
  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    mismatch_count++;
    $display("ERROR %0t: %s expected 0x%0h, got 0x%0h", $realtime, what, want, got);
  endtask

  // Queue a code point and return to waiting for a lead byte
  task automatic emit_cp(input code_point_t cp, input seq_len_t len);
    pending_cps.push_back('{cp: cp, len: len});
    partial_cp = '0;
    seq_len    = LenOne;
  endtask

  // Advance the tracked decoder by one accepted byte
  task automatic decode_byte(input byte_t b);
    if (cont_left == RemNone) begin
      // Lead byte: plain ASCII and the raw bytes 0xF8..0xFF pass straight through
      if (b < LeadTwoMin || b >= LeadRawMin) begin
        pending_cps.push_back('{cp: code_point_t'(b), len: LenOne});
      end else if (b < LeadThreeMin) begin
        // Also catches stray continuation bytes used as a lead
        partial_cp = code_point_t'(b & MaskTwo);
        seq_len    = LenTwo;
        cont_left  = RemOne;
      end else if (b < LeadFourMin) begin
        partial_cp = code_point_t'(b & MaskThree);
        seq_len    = LenThree;
        cont_left  = RemTwo;
      end else begin
        partial_cp = code_point_t'(b & MaskFour);
        seq_len    = LenFour;
        cont_left  = RemThree;
      end
    end else begin
      // Continuation: never checked, merge the low six bits and keep 21 bits
      partial_cp = (partial_cp << ContBits) | code_point_t'(b & MaskCont);
      cont_left  = cont_left - RemOne;
      if (cont_left == RemNone) begin
        emit_cp(partial_cp, seq_len);
      end
    end
  endtask

  // Monitor: predict on every accepted byte, then check every accepted result.
  // Both are sampled at the edge, before this step's drive updates land.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (byte_ch.valid && byte_ch.ready) begin
        decode_byte(byte_ch.in_byte);
      end
      if (cp_ch.valid && cp_ch.ready) begin
        if (pending_cps.size() == 0) begin
          report_mismatch("unexpected result, code_point", 0, cp_ch.code_point);
        end else begin
          oldest_cp = pending_cps.pop_front();
          if (cp_ch.code_point !== oldest_cp.cp) begin
            report_mismatch("code_point", oldest_cp.cp, cp_ch.code_point);
          end
          if (cp_ch.sequence_length !== oldest_cp.len) begin
            report_mismatch("sequence_length", oldest_cp.len, cp_ch.sequence_length);
          end
        end
      end
    end
  end

  // Receiver: while stalling is on, now and then hold ready low for a random burst
  initial begin
    stall_left = 0;
    cp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left != 0) begin
        stall_left--;
        cp_ch.ready <= 1'b0;
      end else if (sink_stall_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 7);
        cp_ch.ready <= 1'b0;
      end else begin
        cp_ch.ready <= 1'b1;
      end
    end
  end

  // Offer one byte, maybe after a short idle burst, and hold it until accepted.
  // Valid stays high on return, so a following call never drops and raises it
  // within one step.
  task automatic send_byte(input byte_t b);
    if (src_idle_on && $urandom_range(0, 4) == 0) begin
      byte_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.in_byte <= b;
    do @(posedge clk_i); while (!byte_ch.ready);
  endtask

  // Drop valid and wait until every queued code point has come out or the drain limit runs out.
  // Let an edge pass first so the last accepted byte is predicted and
  // valid is not driven twice in one step.
  task automatic wait_for_drain();
    byte_ch.valid <= 1'b0;
    @(posedge clk_i);
    for (int i = 0; i < DRAIN_LIMIT && pending_cps.size() != 0; i++) begin
      @(posedge clk_i);
    end
  endtask

  task automatic send_bytes(input byte_t seq[$]);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // ASCII extremes and the raw bytes at 0xF8 and above
  task automatic test_single_byte_codes();
    send_bytes('{8'h00, 8'h7F, LeadRawMin, 8'hFF});
  endtask

  // Two-byte sequences, including a stray continuation byte taken as a lead
  task automatic test_two_byte_sequences();
    send_bytes('{8'hC2, 8'hA9, 8'hDF, 8'hBF, LeadTwoMin, 8'hBF});
  endtask

  // Three-byte sequences; the second one carries lead bytes as continuations
  task automatic test_three_byte_sequences();
    send_bytes('{8'hE2, 8'h82, 8'hAC, 8'hEF, 8'hFF, 8'hF8});
  endtask

  // Four-byte sequences, up to the widest 21-bit code point
  task automatic test_four_byte_sequences();
    send_bytes('{8'hF0, 8'h9F, 8'h98, 8'h80, 8'hF7, 8'hFF, 8'hFF, 8'hFF});
  endtask

  // A zero byte accepted as a continuation
  task automatic test_malformed_continuation();
    send_bytes('{8'hC0, 8'h00});
  endtask

  // Send one sequence: mostly well formed with random payload, sometimes
  // noise or a damaged continuation. Return the number of bytes sent.
  task automatic send_random_sequence(output int unsigned n_sent);
    int unsigned kind;
    int unsigned conts;
    byte_t       lead;
    kind  = $urandom_range(0, 9);
    conts = 0;
    case (kind)
      0, 1: lead = byte_t'($urandom_range(0, 8'h7F));
      2: begin
        lead  = byte_t'($urandom_range(LeadTwoMin, LeadThreeMin - 1));
        conts = 1;
      end
      3, 4: begin
        lead  = byte_t'($urandom_range(LeadThreeMin, LeadFourMin - 1));
        conts = 2;
      end
      5, 6: begin
        lead  = byte_t'($urandom_range(LeadFourMin, LeadRawMin - 1));
        conts = 3;
      end
      7: lead = byte_t'($urandom_range(LeadRawMin, 8'hFF));
      default: lead = byte_t'($urandom_range(0, 8'hFF));
    endcase
    send_byte(lead);
    for (int i = 0; i < conts; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        send_byte(byte_t'($urandom_range(0, 8'hFF)));
      end else begin
        send_byte({2'b10, 6'($urandom_range(0, 63))});
      end
    end
    n_sent = conts + 1;
  endtask

  task automatic send_random_stream(input int unsigned n_bytes);
    int unsigned sent;
    int unsigned n;
    sent = 0;
    while (sent < n_bytes) begin
      send_random_sequence(n);
      sent += n;
    end
  endtask

  task automatic test_random_with_idling();
    src_idle_on   = 1'b1;
    sink_stall_on = 1'b1;
    send_random_stream(500);
  endtask

  // Pause the sender until the decoder has drained, then resume
  task automatic test_pause_for_drain();
    src_idle_on   = 1'b1;
    sink_stall_on = 1'b1;
    send_random_stream(100);
    wait_for_drain();
    send_random_stream(100);
  endtask

  // Back-to-back bytes with the receiver always ready
  task automatic test_random_full_rate();
    src_idle_on   = 1'b0;
    sink_stall_on = 1'b0;
    send_random_stream(500);
  endtask

  initial begin
    mismatch_count = 0;
    cont_left      = RemNone;
    partial_cp     = '0;
    seq_len        = LenOne;
    src_idle_on    = 1'b1;
    sink_stall_on  = 1'b1;

    // Drive every input to a known value while reset is held low
    rst_ni          <= 1'b0;
    byte_ch.valid   <= 1'b0;
    byte_ch.in_byte <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_byte_codes();
    test_two_byte_sequences();
    test_three_byte_sequences();
    test_four_byte_sequences();
    test_malformed_continuation();
    test_random_with_idling();
    test_pause_for_drain();
    test_random_full_rate();

    wait_for_drain();
    repeat (DRAIN_TAIL) @(posedge clk_i);
    if (pending_cps.size() != 0) begin
      report_mismatch("code points never delivered, count", 0, pending_cps.size());
    end

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
